// File: sv/sipc_pkg.sv
`default_nettype none

package sipc_pkg;

    // Field widths of one beat on each channel.
    localparam int LEN_W   = 14;
    localparam int ETYPE_W = 16;
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 64;
    localparam int EVENT_W = 2;

    // Default table size.
    localparam int unsigned DEFAULT_TABLE_ENTRIES = 256;

    // Header length limits and the IPv4 EtherType.
    localparam logic [LEN_W-1:0]   ETH_HEADER_BYTES = LEN_W'(14);
    localparam logic [LEN_W-1:0]   IPV4_MIN_BYTES   = LEN_W'(34);
    localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4   = 16'h0800;

    // Table event codes.
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_INSERT = 2'd1;
    localparam logic [EVENT_W-1:0] EV_INCR   = 2'd2;
    localparam logic [EVENT_W-1:0] EV_FULL   = 2'd3;

    // Lookup status handed from the key table to the pipeline.
    typedef struct packed {
        logic hit;
        logic full;
    } cam_flags_t;

endpackage

`default_nettype wire

// File: sv/sipc_ram.sv
`default_nettype none

// Simple dual-port RAM with one write port and one registered read port.
module sipc_ram
    import sipc_pkg::*;
#(
    parameter int unsigned WIDTH = COUNT_W,
    parameter int unsigned DEPTH = DEFAULT_TABLE_ENTRIES,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [ADDR_W-1:0]      waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic                   re,
    input  wire logic [ADDR_W-1:0]      raddr,
    output      logic [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/sipc_cam.sv
`default_nettype none

// Fully associative key table: every stored key is compared in parallel
// and new keys are appended at the fill pointer.
module sipc_cam
    import sipc_pkg::*;
#(
    parameter int unsigned ENTRIES = DEFAULT_TABLE_ENTRIES,
    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [KEY_W-1:0]   key,
    input  wire logic               insert_en,
    output      logic [ENTRIES-1:0] match_vec,
    output      cam_flags_t         flags,
    output      logic [IDX_W-1:0]   slot
);

    localparam int unsigned OCC_W = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0]   key_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [OCC_W-1:0]   occ_reg;
    logic [OCC_W-1:0]   occ_next;

    always_comb
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            match_vec[j] = valid_reg[j] && (key_reg[j] == key);
        end
    end

    assign flags.hit  = |match_vec;
    assign flags.full = (occ_reg == OCC_W'(ENTRIES));
    assign slot       = occ_reg[IDX_W-1:0];

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        if (insert_en)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (occ_reg == OCC_W'(j))
                begin
                    valid_next[j] = 1'b1;
                end
            end
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
        end
    end

    // Keys need no reset; an entry is only looked at once its valid bit is set.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            if (insert_en && (occ_reg == OCC_W'(j)))
            begin
                key_reg[j] <= key;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/source_ip_packet_counter_core.sv
`default_nettype none

// Channel  Handshake              Beat contents
// -------  ---------------------  ---------------------------------------------
// in       in_valid / in_ready    frame_length[13:0], ether_type[15:0], source_ip[31:0]
// out      out_valid / out_ready  verdict, table_event[1:0], entry_count[63:0]
//
// One result beat leaves for every input beat, and a new beat can be taken in
// every cycle while the pipeline is not held. The stages are: input register,
// parallel key match and insert, counter RAM read, increment and result register.
// Reset clears the entry valid bits and the fill pointer at once; there is no
// clearing pass, so the first beat can be taken right after reset.
// When a result waits and out_ready is low, the whole pipeline holds; an empty
// input register can still take one more beat during that time.
module source_ip_packet_counter_core
    import sipc_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [LEN_W-1:0]   frame_length,
    input  wire logic [ETYPE_W-1:0] ether_type,
    input  wire logic [KEY_W-1:0]   source_ip,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic               verdict,
    output      logic [EVENT_W-1:0] table_event,
    output      logic [COUNT_W-1:0] entry_count
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // The pipeline moves as one whenever the result register is free or drains.
    logic advance;

    // Stage A: input register.
    logic               a_valid_reg;
    logic [LEN_W-1:0]   a_len_reg;
    logic [ETYPE_W-1:0] a_etype_reg;
    logic [KEY_W-1:0]   a_key_reg;

    // Stage B: match result and chosen event.
    logic                     b_valid_reg;
    logic                     b_verdict_reg;
    logic [EVENT_W-1:0]       b_event_reg;
    logic [TABLE_ENTRIES-1:0] b_match_reg;
    logic [IDX_W-1:0]         b_slot_reg;

    // Stage C: counter read in flight.
    logic               c_valid_reg;
    logic               c_verdict_reg;
    logic [EVENT_W-1:0] c_event_reg;
    logic [IDX_W-1:0]   c_idx_reg;
    logic               c_byp_reg;
    logic [COUNT_W-1:0] c_byp_data_reg;

    // Stage D: result register.
    logic               d_valid_reg;
    logic               d_verdict_reg;
    logic [EVENT_W-1:0] d_event_reg;
    logic [COUNT_W-1:0] d_count_reg;

    assign advance  = !d_valid_reg || out_ready;
    assign in_ready = advance || !a_valid_reg;

    // ------------------------------------------------------------------
    // Stage A: classify the frame and look the source address up.
    // ------------------------------------------------------------------
    logic                     a_eth_short;
    logic                     a_is_ipv4;
    logic                     a_ip_short;
    logic                     a_lookup;
    logic                     a_verdict;
    logic [EVENT_W-1:0]       a_event;
    logic                     a_insert;
    logic [TABLE_ENTRIES-1:0] a_match;
    cam_flags_t               a_flags;
    logic [IDX_W-1:0]         a_slot;

    assign a_eth_short = (a_len_reg < ETH_HEADER_BYTES);
    assign a_is_ipv4   = (a_etype_reg == ETHERTYPE_IPV4);
    assign a_ip_short  = (a_len_reg < IPV4_MIN_BYTES);

    // A short Ethernet frame aborts before the EtherType is even looked at;
    // a non-IPv4 frame passes whatever its length beyond the Ethernet header.
    assign a_verdict = !(a_eth_short || (a_is_ipv4 && a_ip_short));
    assign a_lookup  = !a_eth_short && a_is_ipv4 && !a_ip_short;

    always_comb
    begin
        if (!a_lookup)
        begin
            a_event = EV_NONE;
        end
        else if (a_flags.hit)
        begin
            a_event = EV_INCR;
        end
        else if (a_flags.full)
        begin
            a_event = EV_FULL;
        end
        else
        begin
            a_event = EV_INSERT;
        end
    end

    // The key is written as the beat leaves stage A, so the very next beat
    // already sees it in the table.
    assign a_insert = advance && a_valid_reg && (a_event == EV_INSERT);

    sipc_cam #(
        .ENTRIES   (TABLE_ENTRIES)
    ) u_cam (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (a_key_reg),
        .insert_en (a_insert),
        .match_vec (a_match),
        .flags     (a_flags),
        .slot      (a_slot)
    );

    // ------------------------------------------------------------------
    // Stage B: turn the one-hot match into a counter address.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] b_hit_idx;
    logic [IDX_W-1:0] b_idx;

    always_comb
    begin
        b_hit_idx = '0;
        for (int j = 0; j < TABLE_ENTRIES; j++)
        begin
            if (b_match_reg[j])
            begin
                b_hit_idx = b_hit_idx | IDX_W'(j);
            end
        end
    end

    assign b_idx = (b_event_reg == EV_INCR) ? b_hit_idx : b_slot_reg;

    // ------------------------------------------------------------------
    // Stage C: increment the counter, or clear it for a new entry, and write it back.
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] c_rdata;
    logic [COUNT_W-1:0] c_cur;
    logic [COUNT_W-1:0] c_count;
    logic               c_we;

    // A read issued at the same edge as a write to the same entry returns the
    // old word, so the written value is carried alongside and used instead.
    assign c_cur   = c_byp_reg ? c_byp_data_reg : c_rdata;
    assign c_count = (c_event_reg == EV_INCR) ? (c_cur + COUNT_W'(1)) : '0;
    assign c_we    = advance && c_valid_reg
                     && ((c_event_reg == EV_INSERT) || (c_event_reg == EV_INCR));

    sipc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_counts (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_idx_reg),
        .wdata (c_count),
        .re    (advance),
        .raddr (b_idx),
        .rdata (c_rdata)
    );

    // ------------------------------------------------------------------
    // Pipeline registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (advance)
            begin
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_len_reg   <= frame_length;
            a_etype_reg <= ether_type;
            a_key_reg   <= source_ip;
        end
        if (advance)
        begin
            b_verdict_reg  <= a_verdict;
            b_event_reg    <= a_event;
            b_match_reg    <= a_match;
            b_slot_reg     <= a_slot;

            c_verdict_reg  <= b_verdict_reg;
            c_event_reg    <= b_event_reg;
            c_idx_reg      <= b_idx;
            c_byp_reg      <= c_we && (c_idx_reg == b_idx);
            c_byp_data_reg <= c_count;

            d_verdict_reg  <= c_verdict_reg;
            d_event_reg    <= c_event_reg;
            d_count_reg    <= c_count;
        end
    end

    assign out_valid   = d_valid_reg;
    assign verdict     = d_verdict_reg;
    assign table_event = d_event_reg;
    assign entry_count = d_count_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A frame that reached the table always passes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (table_event != EV_NONE)) |-> verdict)
        else $error("table event on an aborted frame");

    // Only an increment reports a nonzero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (table_event != EV_INCR)) |-> (entry_count == '0))
        else $error("nonzero count without an increment");

    // Keys are unique in the table, so at most one entry can match.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> $onehot0(b_match_reg))
        else $error("more than one table entry matched");

    // A held result keeps its contents while the consumer stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(entry_count)
                                       && $stable(table_event)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
